[rtl/fccm_pkg.sv]
// fccm_pkg: request and result types and codes of the cluster chain manager
// no dependencies; imported by the top level and the output stage
`timescale 1ns / 1ps

package fccm_pkg;

  localparam int START_W = 7;
  localparam int COUNT_W = 8;
  localparam int DONE_W  = 8;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_REBUILD = 2'd1;
  localparam logic [1:0] MODE_FREE    = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_NOT_USED = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [START_W-1:0] start_cluster;
    logic [COUNT_W-1:0] cluster_count;
  } fccm_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [START_W-1:0] first_cluster;
    logic [DONE_W-1:0]  clusters_done;
  } fccm_out_t;

endpackage

[rtl/fccm_ram.sv]
// fccm_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies; holds the cluster link table
`timescale 1ns / 1ps

module fccm_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/fccm_out_stage.sv]
// fccm_out_stage: result register between the sequencer and the result channel
// depends on fccm_pkg for the result type
`timescale 1ns / 1ps

module fccm_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_valid,
  input  fccm_pkg::fccm_out_t load_data,
  output logic                load_ready,
  output logic                out_valid,
  input  logic                out_stall,
  output fccm_pkg::fccm_out_t out_data
);

  import fccm_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  fccm_out_t data_r;

  assign load_ready = !valid_r || !out_stall;
  assign out_valid  = valid_r;
  assign out_data   = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load_valid && load_ready) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      data_r <= load_data;
    end
  end

endmodule

[rtl/fat_cluster_chain_manager.sv]
// steps: accept, check and finish states, with the table work between them; the result
// then waits in the output register. table work: mode 0 scans entries from the lowest-free
// hint; mode 1 scans the same way for each added link, then closes the chain; mode 2 frees
// one cluster per walk step, reading on to a free successor where it stops; a scan that
// reads up to the table end and finds nothing reports full. finish holds while the output
// register is full and stalled. one request at a time; after reset the table is cleared.
`timescale 1ns / 1ps

module fat_cluster_chain_manager #(
  parameter int CLUSTERS = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fccm_pkg::fccm_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fccm_pkg::fccm_out_t out_data
);

  import fccm_pkg::*;

  localparam int NW = $clog2(CLUSTERS);
  localparam int DW = (NW + 1 > DONE_W) ? NW + 1 : DONE_W;
  localparam int EW = NW + START_W;

  typedef struct packed {
    logic          used;
    logic          last;
    logic [NW-1:0] next;
  } entry_t;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_CHECK  = 7'b0000100,
    ST_SCAN   = 7'b0001000,
    ST_TAIL   = 7'b0010000,
    ST_WALK   = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [NW-1:0]       clr_r, clr_nxt;
  logic [NW:0]         low_r, low_nxt;
  logic [NW:0]         scan_r, scan_nxt;
  logic                pend_r, pend_nxt;
  logic [NW-1:0]       pend_addr_r, pend_addr_nxt;
  logic [NW-1:0]       cur_r, cur_nxt;
  logic [DW-1:0]       done_r, done_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic [START_W-1:0]  start_r, start_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [START_W-1:0]  first_r, first_nxt;

  logic                ram_we;
  logic [NW-1:0]       ram_waddr;
  entry_t              ram_wdata;
  logic                ram_re;
  logic [NW-1:0]       ram_raddr;
  logic [NW+1:0]       ram_rdata;
  entry_t              rd;

  logic [EW-1:0]       in_start_ext;
  logic [EW-1:0]       start_ext;
  logic [EW-1:0]       found_ext;
  logic                start_ok;
  logic                scan_in_rng;
  logic [DW-1:0]       done_inc;
  logic [DW-1:0]       count_ext;
  logic                walk_stop;

  logic                load_valid;
  logic                load_ready;
  fccm_out_t           load_data;

  fccm_ram #(
    .WIDTH (NW + 2),
    .DEPTH (CLUSTERS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd           = entry_t'(ram_rdata);
  assign in_start_ext = EW'(in_data.start_cluster);
  assign start_ext    = EW'(start_r);
  assign found_ext    = EW'(pend_addr_r);
  assign start_ok     = (start_ext < EW'(CLUSTERS)) && rd.used;
  assign scan_in_rng  = scan_r < (NW + 1)'(CLUSTERS);
  assign done_inc     = done_r + DW'(1);
  assign count_ext    = DW'(count_r);
  assign walk_stop    = rd.last || ((NW + 1)'(rd.next) >= (NW + 1)'(CLUSTERS)) ||
                        (rd.next == cur_r) || (done_inc == DW'(CLUSTERS));

  assign in_stall  = (state_r != ST_IDLE);
  assign load_data = '{status: status_r, first_cluster: first_r,
                       clusters_done: done_r[DONE_W-1:0]};

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    low_nxt       = low_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    cur_nxt       = cur_r;
    done_nxt      = done_r;
    mode_nxt      = mode_r;
    start_nxt     = start_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    first_nxt     = first_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = in_start_ext[NW-1:0];
    load_valid    = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + NW'(1);
        if (clr_r == NW'(CLUSTERS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt   = in_data.mode;
          start_nxt  = in_data.start_cluster;
          count_nxt  = in_data.cluster_count;
          status_nxt = STAT_OK;
          first_nxt  = in_data.start_cluster;
          done_nxt   = '0;
          cur_nxt    = in_start_ext[NW-1:0];
          ram_re     = 1'b1;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // start entry is on the read port now and stays there
        scan_nxt = low_r;
        pend_nxt = 1'b0;
        unique case (mode_r)
          MODE_ALLOC: begin
            state_nxt = ST_SCAN;
          end
          MODE_REBUILD: begin
            if (!start_ok) begin
              status_nxt = STAT_NOT_USED;
              state_nxt  = ST_FINISH;
            end else begin
              done_nxt = DW'(1);
              if (DW'(1) < count_ext) begin
                state_nxt = ST_SCAN;
              end else begin
                state_nxt = ST_TAIL;
              end
            end
          end
          MODE_FREE: begin
            if (!start_ok) begin
              status_nxt = STAT_NOT_USED;
              state_nxt  = ST_FINISH;
            end else begin
              state_nxt = ST_WALK;
            end
          end
          default: begin
            state_nxt = ST_FINISH;
          end
        endcase
      end
      ST_SCAN: begin
        if (pend_r && !rd.used) begin
          // everything below the found entry is taken
          low_nxt = (NW + 1)'(pend_addr_r) + (NW + 1)'(1);
          ram_we  = 1'b1;
          if (mode_r == MODE_ALLOC) begin
            ram_waddr = pend_addr_r;
            ram_wdata = '{used: 1'b1, last: 1'b1, next: '0};
            first_nxt = found_ext[START_W-1:0];
            done_nxt  = DW'(1);
            state_nxt = ST_FINISH;
          end else begin
            // new link stays unwritten until it is linked on or closed
            ram_waddr = cur_r;
            ram_wdata = '{used: 1'b1, last: 1'b0, next: pend_addr_r};
            cur_nxt   = pend_addr_r;
            done_nxt  = done_inc;
            scan_nxt  = (NW + 1)'(pend_addr_r) + (NW + 1)'(1);
            pend_nxt  = 1'b0;
            if (!(done_inc < count_ext)) begin
              state_nxt = ST_TAIL;
            end
          end
        end else if (!pend_r && !scan_in_rng) begin
          status_nxt = STAT_FULL;
          if (mode_r == MODE_ALLOC) begin
            first_nxt = '0;
            done_nxt  = '0;
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_TAIL;
          end
        end else begin
          pend_nxt      = scan_in_rng;
          pend_addr_nxt = scan_r[NW-1:0];
          if (scan_in_rng) begin
            ram_re    = 1'b1;
            ram_raddr = scan_r[NW-1:0];
            scan_nxt  = scan_r + (NW + 1)'(1);
          end
        end
      end
      ST_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = cur_r;
        ram_wdata = '{used: 1'b1, last: 1'b1, next: '0};
        state_nxt = ST_FINISH;
      end
      ST_WALK: begin
        if (!rd.used) begin
          state_nxt = ST_FINISH;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = cur_r;
          done_nxt  = done_inc;
          if ((NW + 1)'(cur_r) < low_r) begin
            low_nxt = (NW + 1)'(cur_r);
          end
          // a self link would read the entry being freed, so it ends the walk
          if (walk_stop) begin
            state_nxt = ST_FINISH;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = rd.next;
            cur_nxt   = rd.next;
          end
        end
      end
      ST_FINISH: begin
        load_valid = 1'b1;
        if (load_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      low_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      low_r   <= low_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r      <= scan_nxt;
    pend_addr_r <= pend_addr_nxt;
    cur_r       <= cur_nxt;
    done_r      <= done_nxt;
    mode_r      <= mode_nxt;
    start_r     <= start_nxt;
    count_r     <= count_nxt;
    status_r    <= status_nxt;
    first_r     <= first_nxt;
  end

  fccm_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (load_valid),
    .load_data  (load_data),
    .load_ready (load_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

`ifndef SYNTHESIS
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("table read and write hit the same entry");

  a_low_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    low_r <= (NW + 1)'(CLUSTERS))
    else $error("free hint past end of table");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_FINISH))
    else $error("result appeared outside finish");

  a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> (done_r <= DW'(CLUSTERS)))
    else $error("cluster count exceeds table size");
`endif

endmodule

[bench/fat_cluster_chain_manager_tb.sv]
// fat_cluster_chain_manager_tb: self-checking bench for the cluster chain manager
// predicts every result from a link table model of its own; needs every file under rtl/
`timescale 1ns / 1ps

module fat_cluster_chain_manager_tb;
  import fccm_pkg::*;

  localparam int CLUSTERS = 128;
  localparam int RANDOM_REQUESTS = 1625;

  class link_table_scoreboard;
    bit        used[CLUSTERS];
    bit        last_mark[CLUSTERS];
    int        next_link[CLUSTERS];
    bit        chain_head[CLUSTERS];
    fccm_out_t expected_results[$];
    int        errors;

    function new();
      foreach (used[k]) begin
        used[k] = 1'b0;
        last_mark[k] = 1'b0;
        next_link[k] = 0;
        chain_head[k] = 1'b0;
      end
      errors = 0;
    endfunction

    function int lowest_free_cluster();
      foreach (used[k]) begin
        if (!used[k]) return k;
      end
      return -1;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // random cluster in use, optionally only chain heads; -1 when none
    function int pick_used(bit heads_only);
      int cand[$];
      foreach (used[k]) begin
        if (used[k] && (!heads_only || chain_head[k])) cand.push_back(k);
      end
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    function void note_request(fccm_in_t req);
      fccm_out_t exp;
      int        s;
      int        cur;
      int        c;
      int        nx;
      int        done;
      int        wanted;
      bit        at_end;
      s = req.start_cluster;
      wanted = req.cluster_count;
      done = 0;
      exp.status = STAT_OK;
      exp.first_cluster = req.start_cluster;
      case (req.mode)
        MODE_ALLOC: begin
          c = lowest_free_cluster();
          if (c >= 0) begin
            used[c] = 1'b1;
            last_mark[c] = 1'b1;
            next_link[c] = 0;
            chain_head[c] = 1'b1;
            exp.first_cluster = c[START_W-1:0];
            done = 1;
          end else begin
            exp.status = STAT_FULL;
            exp.first_cluster = '0;
          end
        end
        MODE_REBUILD: begin
          if (!used[s]) begin
            exp.status = STAT_NOT_USED;
          end else begin
            cur = s;
            done = 1;
            chain_head[s] = 1'b1;
            for (int i = 1; i < wanted; i++) begin
              c = lowest_free_cluster();
              if (c < 0) begin
                exp.status = STAT_FULL;
                break;
              end
              last_mark[cur] = 1'b0;
              next_link[cur] = c;
              used[c] = 1'b1;
              last_mark[c] = 1'b0;
              next_link[c] = 0;
              chain_head[c] = 1'b0;
              cur = c;
              done++;
            end
            last_mark[cur] = 1'b1;
            next_link[cur] = 0;
          end
        end
        MODE_FREE: begin
          if (!used[s]) begin
            exp.status = STAT_NOT_USED;
          end else begin
            cur = s;
            while (done < CLUSTERS) begin
              at_end = last_mark[cur];
              nx = next_link[cur];
              used[cur] = 1'b0;
              last_mark[cur] = 1'b0;
              next_link[cur] = 0;
              chain_head[cur] = 1'b0;
              done++;
              // walk stops at the end mark, at a link out of range or at a link into a free cluster
              if (at_end || nx >= CLUSTERS || !used[nx]) break;
              cur = nx;
            end
          end
        end
        default: ;
      endcase
      exp.clusters_done = done[DONE_W-1:0];
      expected_results.push_back(exp);
    endfunction

    function void check_result(fccm_out_t res);
      fccm_out_t exp;
      if (expected_results.size() == 0) begin
        $error("result with no request pending: status %0d first %0d done %0d",
               res.status, res.first_cluster, res.clusters_done);
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      if (res.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, res.status);
        errors++;
      end
      if (res.first_cluster !== exp.first_cluster) begin
        $error("first_cluster: expected %0d, got %0d", exp.first_cluster, res.first_cluster);
        errors++;
      end
      if (res.clusters_done !== exp.clusters_done) begin
        $error("clusters_done: expected %0d, got %0d", exp.clusters_done, res.clusters_done);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  fccm_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  fccm_out_t out_data;

  link_table_scoreboard sb = new();
  int burst_left = 0;
  int stall_regime = 0;
  int regime_cycles = 0;

  always #4 clk = ~clk;

  fat_cluster_chain_manager #(
    .CLUSTERS(CLUSTERS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // result side: check accepted results, stall in changing regimes
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (regime_cycles == 0) begin
      stall_regime = $urandom_range(0, 3);
      regime_cycles = $urandom_range(50, 300);
    end else begin
      regime_cycles--;
    end
    case (stall_regime)
      0, 1: out_stall <= 1'b0;
      2: out_stall <= ($urandom_range(0, 99) < 30);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  function automatic fccm_in_t make_request(logic [1:0] mode, int start, int count);
    fccm_in_t req;
    req.mode = mode;
    req.start_cluster = start[START_W-1:0];
    req.cluster_count = count[COUNT_W-1:0];
    return req;
  endfunction

  task automatic send_request(input fccm_in_t req);
    int gap;
    in_data <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic fccm_in_t random_request();
    int          r;
    int          start;
    int          count;
    logic [1:0]  mode;
    r = $urandom_range(0, 99);
    if (r < 35) mode = MODE_ALLOC;
    else if (r < 65) mode = MODE_REBUILD;
    else if (r < 98) mode = MODE_FREE;
    else mode = 2'd3;
    // mostly chains that exist, sometimes any cluster
    if ($urandom_range(0, 99) < 80)
      start = sb.pick_used($urandom_range(0, 99) < 60);
    else
      start = -1;
    if (start < 0) start = $urandom_range(0, CLUSTERS - 1);
    r = $urandom_range(0, 99);
    if (r < 70) count = $urandom_range(1, 6);
    else if (r < 90) count = $urandom_range(7, 40);
    else if (r < 98) count = $urandom_range(41, 128);
    else count = $urandom_range(0, 255);
    return make_request(mode, start, count);
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, short chains, zero length, old chain left in use
    send_request(make_request(MODE_FREE, 0, 1));
    send_request(make_request(MODE_REBUILD, 127, 3));
    send_request(make_request(MODE_ALLOC, 127, 255));
    send_request(make_request(MODE_ALLOC, 0, 0));
    send_request(make_request(MODE_REBUILD, 0, 0));
    send_request(make_request(MODE_REBUILD, 0, 5));
    send_request(make_request(MODE_REBUILD, 0, 2));
    send_request(make_request(MODE_FREE, 0, 128));
    send_request(make_request(MODE_FREE, 2, 1));
    send_request(make_request(2'd3, 85, 170));
    // fill the table, then full cases and a chain broken in the middle
    send_request(make_request(MODE_REBUILD, 1, 128));
    send_request(make_request(MODE_ALLOC, 42, 7));
    send_request(make_request(MODE_REBUILD, 1, 255));
    send_request(make_request(MODE_FREE, 64, 1));
    send_request(make_request(MODE_REBUILD, 0, 128));
    send_request(make_request(MODE_FREE, 1, 1));
    send_request(make_request(MODE_FREE, 0, 1));
    send_request(make_request(MODE_FREE, 2, 1));
    send_request(make_request(MODE_FREE, 127, 1));
    // longest chain built and freed in one request each
    send_request(make_request(MODE_ALLOC, 0, 1));
    send_request(make_request(MODE_REBUILD, 0, 128));
    send_request(make_request(MODE_FREE, 0, 1));
    send_request(make_request(2'd3, 127, 0));
    wait_all_results();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 400 == 399) wait_all_results();
      send_request(random_request());
    end

    wait_all_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[fat_cluster_chain_manager] OK");
    end else begin
      $display("[fat_cluster_chain_manager] ERROR");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("[fat_cluster_chain_manager] ERROR");
    $finish;
  end

endmodule

[files.f]
rtl/fccm_pkg.sv
rtl/fccm_ram.sv
rtl/fccm_out_stage.sv
rtl/fat_cluster_chain_manager.sv
bench/fat_cluster_chain_manager_tb.sv
